// File: hdl/wcma_pkg.sv
// Shared types, widths and the arctangent table of the weighted circular mean block.
package wcma_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;
	localparam int LANES             = 4;
	localparam int DIV_N             = 48;
	localparam int DIV_D             = 16;
	localparam int ROT_W             = 34;
	localparam int SUM_W             = 36;
	localparam int VEC_W             = 38;
	localparam int SCALE_W           = 7;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd10;
	localparam logic [15:0] DEG_TURN = 16'd360;

	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic [15:0] row0_angle;
		logic [15:0] row1_angle;
		logic [15:0] row2_angle;
		logic [15:0] row3_angle;
		logic [7:0]  row0_weight;
		logic [7:0]  row1_weight;
		logic [7:0]  row2_weight;
		logic [7:0]  row3_weight;
		logic [11:0] row0_peak;
		logic [11:0] row1_peak;
		logic [11:0] row2_peak;
		logic [11:0] row3_peak;
	} wcma_in_t;

	typedef struct packed {
		logic [15:0] mean_angle;
		logic        zero_peak_fault;
	} wcma_out_t;

endpackage

// File: hdl/wcma_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module wcma_div #(
	parameter int NUM_W = wcma_pkg::DIV_N,
	parameter int DEN_W = wcma_pkg::DIV_D
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W+1];
	logic [NUM_W-1:0] quo_s [NUM_W+1];
	logic [NUM_W-1:0] num_s [NUM_W+1];
	logic [DEN_W-1:0] den_s [NUM_W+1];

	assign rem_s[0] = '0;
	assign quo_s[0] = '0;
	assign num_s[0] = num;
	assign den_s[0] = den;
	assign quo      = quo_s[NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;
		logic [NUM_W-1:0] quo_next;
		always_comb begin
			trial    = {rem_s[k], num_s[k][NUM_W-1-k]};
			diff     = trial - {1'b0, den_s[k]};
			ge       = (trial >= {1'b0, den_s[k]});
			quo_next = quo_s[k];
			quo_next[NUM_W-1-k] = ge;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[k+1] <= quo_next;
				num_s[k+1] <= num_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

endmodule

// File: hdl/wcma_lane.sv
// One row lane: corrected weight, angle conversion and CORDIC rotation.
module wcma_lane #(
	parameter int CORDIC_STAGES = wcma_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [15:0]                         angle,
	input  logic [7:0]                          weight,
	input  logic [11:0]                         peak,
	input  logic [13:0]                         peak_sum,
	input  logic [wcma_pkg::DIV_D-1:0]          turn_div,
	output logic signed [wcma_pkg::ROT_W-1:0]   x,
	output logic signed [wcma_pkg::ROT_W-1:0]   y
);

	localparam int N = wcma_pkg::DIV_N;
	localparam int W = wcma_pkg::ROT_W;

	logic [N-1:0] q_quo;
	logic [N-1:0] th_quo;
	logic [7:0]   wt_s [N];

	wcma_div u_qdiv (
		.clk (clk),
		.en  (en),
		.num ({18'd0, peak_sum, 16'd0}),
		.den ({4'd0, peak}),
		.quo (q_quo)
	);

	wcma_div u_thdiv (
		.clk (clk),
		.en  (en),
		.num ({angle, 32'd0}),
		.den (turn_div),
		.quo (th_quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			wt_s[0] <= weight;
			for (int k = 1; k < N; k++) begin
				wt_s[k] <= wt_s[k-1];
			end
		end
	end

	// Corrected weight and quadrant fold into the range of the rotator.
	logic [30:0]         wsum;
	logic signed [W-1:0] w_ext;
	logic signed [W-1:0] r_in;
	logic signed [W-1:0] x0;
	logic signed [W-1:0] r0;

	always_comb begin
		wsum  = {7'd0, wt_s[N-1], 16'd0} + {1'b0, q_quo[29:0]};
		w_ext = {4'd0, wsum[30:1]};
		r_in  = {{(W-32){th_quo[31]}}, th_quo[31:0]};
		x0    = w_ext;
		r0    = r_in;
		if (r_in > 34'sd1073741824) begin
			x0 = -w_ext;
			r0 = r_in - 34'sd2147483648;
		end else if (r_in < -34'sd1073741824) begin
			x0 = -w_ext;
			r0 = r_in + 34'sd2147483648;
		end
	end

	logic signed [W-1:0] rx_s [CORDIC_STAGES+1];
	logic signed [W-1:0] ry_s [CORDIC_STAGES+1];
	logic signed [W-1:0] rr_s [CORDIC_STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0] <= x0;
			ry_s[0] <= '0;
			rr_s[0] <= r0;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		localparam logic signed [W-1:0] ATAN = {2'b00, wcma_pkg::ATAN_TAB[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (rr_s[i] >= 0) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					rr_s[i+1] <= rr_s[i] - ATAN;
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					rr_s[i+1] <= rr_s[i] + ATAN;
				end
			end
		end
	end

	assign x = rx_s[CORDIC_STAGES];
	assign y = ry_s[CORDIC_STAGES];

endmodule

// File: hdl/wcma_merge.sv
// Merging stage: vector sum tree, CORDIC vectoring and scaling of the angle.
module wcma_merge #(
	parameter int CORDIC_STAGES = wcma_pkg::CORDIC_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [wcma_pkg::ROT_W-1:0] lx [wcma_pkg::LANES],
	input  logic signed [wcma_pkg::ROT_W-1:0] ly [wcma_pkg::LANES],
	input  logic [wcma_pkg::DIV_D-1:0]        turn_div,
	output logic [15:0]                       mean
);

	localparam int RW = wcma_pkg::ROT_W;
	localparam int SW = wcma_pkg::SUM_W;
	localparam int VW = wcma_pkg::VEC_W;

	logic signed [RW:0]   px_s1 [2];
	logic signed [RW:0]   py_s1 [2];
	logic signed [SW-1:0] sx_s2;
	logic signed [SW-1:0] sy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 2; p++) begin
				px_s1[p] <= (RW+1)'(lx[2*p]) + (RW+1)'(lx[2*p+1]);
				py_s1[p] <= (RW+1)'(ly[2*p]) + (RW+1)'(ly[2*p+1]);
			end
			sx_s2 <= SW'(px_s1[0]) + SW'(px_s1[1]);
			sy_s2 <= SW'(py_s1[0]) + SW'(py_s1[1]);
		end
	end

	logic signed [VW-1:0] vx_s [CORDIC_STAGES+1];
	logic signed [VW-1:0] vy_s [CORDIC_STAGES+1];
	logic [31:0]          vz_s [CORDIC_STAGES+1];
	logic                 nil_s [CORDIC_STAGES+1];
	logic signed [VW-1:0] ex;
	logic signed [VW-1:0] ey;

	assign ex = VW'(sx_s2);
	assign ey = VW'(sy_s2);

	// Left half-plane sums are turned by half a turn before vectoring.
	always_ff @(posedge clk) begin
		if (en) begin
			nil_s[0] <= (sx_s2 == 0) && (sy_s2 == 0);
			if (sx_s2 < 0) begin
				vx_s[0] <= -ex;
				vy_s[0] <= -ey;
				vz_s[0] <= 32'h80000000;
			end else begin
				vx_s[0] <= ex;
				vy_s[0] <= ey;
				vz_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				nil_s[i+1] <= nil_s[i];
				if (vy_s[i] > 0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + wcma_pkg::ATAN_TAB[i];
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - wcma_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	logic [47:0] prod;
	assign prod = {16'd0, vz_s[CORDIC_STAGES]} * {32'd0, turn_div};

	always_ff @(posedge clk) begin
		if (en) begin
			mean <= nil_s[CORDIC_STAGES] ? 16'd0 : prod[47:32];
		end
	end

endmodule

// File: hdl/weighted_circular_mean_angle.sv
// Top level of the weighted circular mean angle block.
// Each input beat carries four sensor rows; four lanes work on them side by side. A lane
// divides the sum of peaks by its own peak and the row angle by 360*angle_scale in two
// pipelined restoring dividers of 48 stages each, forms the corrected weight and rotates
// it to the row angle with a CORDIC_STAGES-stage rotator. The merging stage adds the four
// vectors in a two-level registered tree, takes the angle of the sum with a
// CORDIC_STAGES-stage vectoring unit and scales it with one multiplier. A new beat is
// taken every cycle unless the pipeline halts; a result passes through the dividers, the two
// CORDIC pipelines, the merging registers and the output register. The pipeline only
// halts when a finished result waits in the output register and the last stage is also
// full. A zero peak on any row gives the fault flag and an angle of 0. angle_scale is
// written through the cfg channel, which is always ready, and must only change while the
// block holds no work; a value of 0 acts as 1.
module weighted_circular_mean_angle #(
	parameter int CORDIC_STAGES = wcma_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  wcma_pkg::wcma_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output wcma_pkg::wcma_out_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wcma_pkg::SCALE_W-1:0]  cfg_data
);

	localparam int LANES = wcma_pkg::LANES;
	localparam int LAT   = wcma_pkg::DIV_N + 5 + 2 * CORDIC_STAGES;

	logic [wcma_pkg::SCALE_W-1:0] scale_q;
	logic [wcma_pkg::SCALE_W-1:0] eff_scale;
	logic [wcma_pkg::DIV_D-1:0]   turn_div;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= wcma_pkg::SCALE_RESET;
		end else if (cfg_valid) begin
			scale_q <= cfg_data;
		end
	end

	// One full turn in input units; a zero scale is treated as one.
	assign eff_scale = (scale_q == '0) ? 7'd1 : scale_q;
	assign turn_div  = 16'({9'd0, eff_scale} * wcma_pkg::DEG_TURN);

	// The whole pipeline moves together. It stalls only when the output register
	// holds an untaken result and the last stage has one ready to follow it.
	logic en;
	logic vld_s [LAT];
	logic flt_s [LAT];

	assign en       = out_ready || !out_valid || !vld_s[LAT-1];
	assign in_ready = en;

	logic [15:0] angles  [LANES];
	logic [7:0]  weights [LANES];
	logic [11:0] peaks   [LANES];
	logic [13:0] peak_sum;
	logic        fault;

	always_comb begin
		angles[0]  = in_data.row0_angle;
		angles[1]  = in_data.row1_angle;
		angles[2]  = in_data.row2_angle;
		angles[3]  = in_data.row3_angle;
		weights[0] = in_data.row0_weight;
		weights[1] = in_data.row1_weight;
		weights[2] = in_data.row2_weight;
		weights[3] = in_data.row3_weight;
		peaks[0]   = in_data.row0_peak;
		peaks[1]   = in_data.row1_peak;
		peaks[2]   = in_data.row2_peak;
		peaks[3]   = in_data.row3_peak;
		peak_sum   = '0;
		fault      = 1'b0;
		for (int r = 0; r < LANES; r++) begin
			peak_sum = peak_sum + 14'(peaks[r]);
			fault    = fault | (peaks[r] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flt_s[0] <= fault;
			for (int k = 1; k < LAT; k++) begin
				flt_s[k] <= flt_s[k-1];
			end
		end
	end

	logic signed [wcma_pkg::ROT_W-1:0] lx [LANES];
	logic signed [wcma_pkg::ROT_W-1:0] ly [LANES];

	for (genvar r = 0; r < LANES; r++) begin : g_lane
		wcma_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane (
			.clk      (clk),
			.en       (en),
			.angle    (angles[r]),
			.weight   (weights[r]),
			.peak     (peaks[r]),
			.peak_sum (peak_sum),
			.turn_div (turn_div),
			.x        (lx[r]),
			.y        (ly[r])
		);
	end

	logic [15:0] mean;

	wcma_merge #(.CORDIC_STAGES(CORDIC_STAGES)) u_merge (
		.clk      (clk),
		.en       (en),
		.lx       (lx),
		.ly       (ly),
		.turn_div (turn_div),
		.mean     (mean)
	);

	// Output register: loads whenever it is empty or its beat is being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready || !out_valid) begin
			out_valid <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid) begin
			out_data.mean_angle      <= flt_s[LAT-1] ? 16'd0 : mean;
			out_data.zero_peak_fault <= flt_s[LAT-1];
		end
	end

endmodule

// File: hdl/wcma_checker.sv
// Port-level checks for the weighted circular mean angle block, bound to the top level.
module wcma_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input wcma_pkg::wcma_out_t           out_data,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_peak_fault |-> out_data.mean_angle == 16'd0)
		else $error("fault beat carries a non-zero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.mean_angle < 16'd45720)
		else $error("angle beyond one scaled turn");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration beat refused");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with an empty output register");

endmodule

bind weighted_circular_mean_angle wcma_checker u_wcma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

// File: tb/weighted_circular_mean_angle_tb.sv
// Self-checking testbench of the weighted circular mean angle block.
module weighted_circular_mean_angle_tb;

	// The longest path through the block, plus room for the output register.
	localparam int PIPE_DEPTH  = 54 + 2*wcma_pkg::CORDIC_STAGES_DEF + 16;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 200;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	wcma_pkg::wcma_in_t            in_data;
	logic                          out_valid;
	logic                          out_ready;
	wcma_pkg::wcma_out_t           out_data;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [wcma_pkg::SCALE_W-1:0]  cfg_data;

	// Frames waiting to be offered, and the results that accepted frames are owed.
	wcma_pkg::wcma_in_t  frames_pending[$];
	wcma_pkg::wcma_out_t means_due[$];

	int unsigned scale_now;      // the angle_scale the block currently holds
	int unsigned idle_pct;       // chance in a hundred that either side idles
	int unsigned hold_asked;     // bumped by the sequencer to ask for a long hold-off
	int unsigned hold_done;
	int unsigned hold_left;
	int unsigned mismatches;
	int unsigned frames_sent;
	int unsigned means_seen;
	int unsigned faults_seen;
	int unsigned quiet_cycles;

	weighted_circular_mean_angle DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Rotates the vector (w, 0) to the binary angle theta, uncorrected for gain.
	task automatic rotate_row(input longint w, input longint theta,
			output longint ox, output longint oy);
		longint x, y, r, nx;
		x = w;
		y = 0;
		r = theta;
		if (r >= 64'sh8000_0000)
			r = r - 64'sh1_0000_0000;
		if (r > 64'sh4000_0000) begin
			x = -x;
			r = r - 64'sh8000_0000;
		end else if (r < -64'sh4000_0000) begin
			x = -x;
			r = r + 64'sh8000_0000;
		end
		for (int i = 0; i < wcma_pkg::CORDIC_STAGES_DEF && i < wcma_pkg::ATAN_LEN; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				r  = r - longint'(wcma_pkg::ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				r  = r + longint'(wcma_pkg::ATAN_TAB[i]);
			end
			x = nx;
		end
		ox = x;
		oy = y;
	endtask

	// The angle of the vector sum, as a binary angle in [0, 2^32).
	function automatic longint sum_angle(input longint sx, input longint sy);
		longint x, y, z, nx;
		x = sx;
		y = sy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 64'sh8000_0000;
		end
		for (int i = 0; i < wcma_pkg::CORDIC_STAGES_DEF && i < wcma_pkg::ATAN_LEN; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + longint'(wcma_pkg::ATAN_TAB[i]);
			end else begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - longint'(wcma_pkg::ATAN_TAB[i]);
			end
			x = nx;
		end
		return z & 64'sh0_FFFF_FFFF;
	endfunction

	// Works out the mean angle and fault flag that one frame must give.
	task automatic predict_mean(input wcma_pkg::wcma_in_t f, input int unsigned scale_reg,
			output wcma_pkg::wcma_out_t res);
		longint unsigned ang[4], wt[4], pk[4], total, q, w, th, z, sc;
		longint sx, sy, vx, vy;
		bit fault;
		ang   = '{f.row0_angle, f.row1_angle, f.row2_angle, f.row3_angle};
		wt    = '{f.row0_weight, f.row1_weight, f.row2_weight, f.row3_weight};
		pk    = '{f.row0_peak, f.row1_peak, f.row2_peak, f.row3_peak};
		sc    = (scale_reg == 0) ? 1 : scale_reg;
		total = 0;
		fault = 1'b0;
		sx    = 0;
		sy    = 0;
		for (int i = 0; i < 4; i++) begin
			total = total + pk[i];
			if (pk[i] == 0)
				fault = 1'b1;
		end
		if (fault) begin
			res.mean_angle      = '0;
			res.zero_peak_fault = 1'b1;
			return;
		end
		for (int i = 0; i < 4; i++) begin
			q  = (total << 16) / pk[i];
			w  = ((wt[i] << 16) + q) >> 1;
			th = ((ang[i] << 32) / (360 * sc)) & 64'h0_FFFF_FFFF;
			rotate_row(longint'(w), longint'(th), vx, vy);
			sx = sx + vx;
			sy = sy + vy;
		end
		z = longint'(sum_angle(sx, sy));
		res.mean_angle      = 16'((z * 360 * sc) >> 32);
		res.zero_peak_fault = 1'b0;
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
			means_seen);
		mismatches++;
	endtask

	// Driver: offers the oldest pending frame, holding it until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		wcma_pkg::wcma_out_t owed;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_mean(in_data, scale_now, owed);
				means_due.push_back(owed);
				frames_sent++;
			end
			if (!in_valid || in_ready) begin
				if (frames_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= frames_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares every accepted result beat with the oldest one owed, and
	// throttles out_ready, including the long hold-off that fills the pipeline.
	always @(posedge clk or negedge arst_n) begin
		wcma_pkg::wcma_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (means_due.size() == 0) begin
					report_mismatch("results owed at a result beat", 0, 1);
				end else begin
					want = means_due.pop_front();
					if (out_data.mean_angle !== want.mean_angle)
						report_mismatch("mean_angle", out_data.mean_angle, want.mean_angle);
					if (out_data.zero_peak_fault !== want.zero_peak_fault)
						report_mismatch("zero_peak_fault", out_data.zero_peak_fault,
							want.zero_peak_fault);
					if (want.zero_peak_fault)
						faults_seen++;
				end
				means_seen++;
			end
			if (hold_done != hold_asked) begin
				hold_done <= hold_asked;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Watchdog: any beat on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// A random frame: angles mostly inside one turn at the present scale, now and then
	// anywhere in 16 bits so that wrapping is covered; a few zero or extreme peaks.
	function automatic wcma_pkg::wcma_in_t random_frame(input int unsigned sc);
		wcma_pkg::wcma_in_t f;
		int unsigned turn;
		logic [15:0] a[4];
		logic [7:0]  w[4];
		logic [11:0] p[4];
		turn = 360 * ((sc == 0) ? 1 : sc);
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(9) == 0)
				a[i] = 16'($urandom);
			else
				a[i] = 16'($urandom_range(turn - 1, 0));
			w[i] = 8'($urandom);
			case ($urandom_range(39))
				0:       p[i] = 12'd0;
				1:       p[i] = 12'd4095;
				2:       p[i] = 12'd1;
				default: p[i] = 12'($urandom_range(4095, 1));
			endcase
		end
		f = '{a[0], a[1], a[2], a[3], w[0], w[1], w[2], w[3], p[0], p[1], p[2], p[3]};
		return f;
	endfunction

	function automatic wcma_pkg::wcma_in_t frame_of(input logic [15:0] a0, a1, a2, a3,
			input logic [7:0] w, input logic [11:0] p0, p1, p2, p3);
		wcma_pkg::wcma_in_t f;
		f = '{a0, a1, a2, a3, w, w, w, w, p0, p1, p2, p3};
		return f;
	endfunction

	// Lets every owed result drain, then the pipeline settle, before a register write.
	task automatic drain_block();
		while (frames_pending.size() > 0 || in_valid || means_due.size() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic write_scale(input int unsigned v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= wcma_pkg::SCALE_W'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		scale_now = v & 7'h7F;
	endtask

	// Sequencer: a directed opening at the reset scale, then random phases at several
	// scales, the extremes and the zero that behaves as one among them.
	initial begin
		int unsigned scales[7];
		scales       = '{10, 1, 100, 0, 127, 37, 10};
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		scale_now    = wcma_pkg::SCALE_RESET;
		idle_pct     = 30;
		hold_asked   = 0;
		mismatches   = 0;
		frames_sent  = 0;
		means_seen   = 0;
		faults_seen  = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames: all-zero, all-maximum, the compass points, opposing rows
		// that cancel, a zero peak on each row in turn, and angles of a turn or more.
		frames_pending.push_back(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
		frames_pending.push_back(frame_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
		frames_pending.push_back(frame_of(0, 0, 0, 0, 0, 1, 1, 1, 1));
		frames_pending.push_back(frame_of(900, 900, 900, 900, 8'd5, 9, 9, 9, 9));
		frames_pending.push_back(frame_of(1800, 1800, 1800, 1800, 8'd5, 9, 9, 9, 9));
		frames_pending.push_back(frame_of(2700, 2700, 2700, 2700, 8'd5, 9, 9, 9, 9));
		frames_pending.push_back(frame_of(0, 900, 1800, 2700, 8'd7, 50, 50, 50, 50));
		frames_pending.push_back(frame_of(0, 1800, 0, 1800, 8'd3, 8, 8, 8, 8));
		frames_pending.push_back(frame_of(450, 2250, 1350, 3150, 8'hFF, 4095, 4095,
			4095, 4095));
		frames_pending.push_back(frame_of(100, 200, 300, 400, 8'd1, 0, 5, 5, 5));
		frames_pending.push_back(frame_of(100, 200, 300, 400, 8'd1, 5, 0, 5, 5));
		frames_pending.push_back(frame_of(100, 200, 300, 400, 8'd1, 5, 5, 0, 5));
		frames_pending.push_back(frame_of(100, 200, 300, 400, 8'd1, 5, 5, 5, 0));
		frames_pending.push_back(frame_of(3599, 3599, 3600, 3600, 8'd9, 1, 4095, 1,
			4095));
		frames_pending.push_back(frame_of(3600, 7200, 36000, 40000, 8'd128, 2048, 1,
			3000, 77));
		frames_pending.push_back(frame_of(3599, 1, 3598, 2, 8'd0, 4095, 4095, 1, 1));

		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				drain_block();
				write_scale(scales[ph]);
			end
			// One phase runs with no idling at all; the one before it starts with a long hold-off
			// of the receiver while frames keep coming.
			idle_pct = (ph == 2) ? 0 : 30;
			if (ph == 1)
				hold_asked++;
			for (int n = 0; n < PHASE_ITEMS; n++)
				frames_pending.push_back(random_frame(scale_now));
		end

		drain_block();
		$display("covered %0d frames in seven settings of angle_scale, %0d with a zero peak,",
			frames_sent, faults_seen);
		$display("with random idling, one phase without gaps and one long output hold-off");
		if (mismatches == 0 && means_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
